// ----- design/iso_date_time_to_epoch_parser_unit_defines.svh -----
// Assertion macros for the ISO date/time parser unit.
// Taken in by the top level; relies on signals named clock and reset.
`ifndef ISO_DATE_TIME_TO_EPOCH_PARSER_UNIT_DEFINES_SVH
`define ISO_DATE_TIME_TO_EPOCH_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ISOEP_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("isoep: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define ISOEP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("isoep: next-cycle check failed");

`endif

// ----- design/isoep_pkg.sv -----
// Shared types and constants for the ISO date/time to epoch parser.
// No dependencies; used by isoep_ctrl, isoep_datapath and the top level.
package isoep_pkg;

   // Channel payloads
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_token;
   } req_type;

   typedef struct packed {
      logic signed [38:0] epoch_value;
      logic               format_error;
   } rsp_type;

   // Controller states: parse, then the fixed conversion sequence
   typedef enum logic [2:0] {
      ST_PARSE,
      ST_ADJUST,
      ST_ERA,
      ST_YOE,
      ST_DOE,
      ST_DAYS,
      ST_SECS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take_char;   // a character transfer this cycle
      logic capture;     // token's last character: latch fields, clear parser
      logic load_out;    // load the result register
   } cmd_type;

   typedef struct packed {
      logic last_char;   // presented character ends the token
   } status_type;

   // Characters
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Pattern lengths
   localparam logic [4:0] DATE_LEN  = 5'd10;
   localparam logic [4:0] STAMP_LEN = 5'd19;

   // Separator positions
   localparam logic [4:0] POS_DASH_YM  = 5'd4;
   localparam logic [4:0] POS_DASH_MD  = 5'd7;
   localparam logic [4:0] POS_SPACE    = 5'd10;
   localparam logic [4:0] POS_COLON_HM = 5'd13;
   localparam logic [4:0] POS_COLON_MS = 5'd16;

   // Last position of each digit group
   localparam logic [4:0] POS_YEAR_LAST   = 5'd3;
   localparam logic [4:0] POS_MONTH_LAST  = 5'd6;
   localparam logic [4:0] POS_DAY_LAST    = 5'd9;
   localparam logic [4:0] POS_HOUR_LAST   = 5'd12;
   localparam logic [4:0] POS_MINUTE_LAST = 5'd15;

   // Era arithmetic
   localparam int ERA_DAYS     = 146097;
   localparam int EPOCH_SHIFT  = 719468;
   localparam int DAY_SECONDS  = 86400;
   localparam int ERA_YEARS    = 400;
   // reciprocals: x/25 = (x*1311)>>15, x/5 = (x*13108)>>16, x/100 = (x*41)>>12
   localparam int RECIP_25     = 1311;
   localparam int RECIP_5      = 13108;
   localparam int RECIP_100    = 41;

endpackage

// ----- design/isoep_ctrl.sv -----
// Controller for the ISO date/time parser: handshakes and conversion sequence.
// Depends on isoep_pkg.
module isoep_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  isoep_pkg::status_type  status,
   output isoep_pkg::cmd_type     cmd
);
   import isoep_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_PARSE:  begin
            if (req_valid && status.last_char) state_in = ST_ADJUST;
         end
         ST_ADJUST: state_in = ST_ERA;
         ST_ERA:    state_in = ST_YOE;
         ST_YOE:    state_in = ST_DOE;
         ST_DOE:    state_in = ST_DAYS;
         ST_DAYS:   state_in = ST_SECS;
         ST_SECS:   state_in = ST_DONE;
         ST_DONE:   begin
            if (out_free) state_in = ST_PARSE;
         end
         default:   state_in = ST_PARSE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_PARSE: begin
            req_stall     = 1'b0;
            cmd.take_char = req_valid;
            cmd.capture   = req_valid && status.last_char;
         end
         ST_DONE: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Result valid: set on load, held while stalled
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PARSE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/isoep_datapath.sv -----
// Datapath for the ISO date/time parser: character matcher, digit gathering,
// staged days-from-civil conversion and result register. Depends on isoep_pkg.
module isoep_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  isoep_pkg::req_type     req_data,
   input  logic                   csr_valid,
   input  logic                   csr_data,
   input  isoep_pkg::cmd_type     cmd,
   output isoep_pkg::status_type  status,
   output isoep_pkg::rsp_type     rsp_data
);
   import isoep_pkg::*;

   // Mode register
   logic fmt_ff;

   // Parser state
   logic [4:0]  pos_ff, pos_in;
   logic        skip_ff, skip_in;
   logic        mis_ff, mis_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;

   logic        is_blank, is_digit;
   logic [3:0]  digit;
   logic [7:0]  need_sep;
   logic [4:0]  pat_len;

   // Captured token, stable through the conversion
   logic [13:0] c_year_ff;
   logic [6:0]  c_month_ff, c_day_ff, c_hour_ff, c_minute_ff, c_second_ff;
   logic        c_mode_ff, c_err_ff;

   // Conversion stages
   logic signed [14:0] s1_year_ff, s1_year_in;
   logic [6:0]         s1_mi_ff, s1_mi_in;
   logic signed [5:0]  s2_era_ff, s2_era_in;
   logic [14:0]        s2_t_ff, s2_t_in;
   logic [19:0]        era_prod;
   logic [8:0]         s3_yoe_ff, s3_yoe_in;
   logic signed [12:0] s3_doy_ff, s3_doy_in;
   logic signed [15:0] era_years;
   logic signed [15:0] yoe_wide;
   logic [27:0]        doy_prod;
   logic signed [18:0] s4_doe_ff, s4_doe_in;
   logic signed [22:0] s4_eradays_ff, s4_eradays_in;
   logic [18:0]        s4_hms_ff, s4_hms_in;
   logic [18:0]        yoe_term;
   logic [13:0]        cent_prod;
   logic signed [22:0] s5_days_ff, s5_days_in;
   logic signed [39:0] s6_prod_ff, s6_prod_in;
   logic signed [38:0] final_value;

   rsp_type rsp_data_ff;

   assign status.last_char = req_data.end_of_token;

   // Character classification
   always_comb begin
      is_blank = (req_data.char_code == CHAR_SPACE) || (req_data.char_code == CHAR_TAB);
      is_digit = (req_data.char_code >= CHAR_ZERO) && (req_data.char_code <= CHAR_NINE);
      digit    = 4'(req_data.char_code - CHAR_ZERO);
      pat_len  = fmt_ff ? STAMP_LEN : DATE_LEN;
      case (pos_ff) inside
         POS_DASH_YM, POS_DASH_MD:   need_sep = CHAR_DASH;
         POS_SPACE:                  need_sep = CHAR_SPACE;
         POS_COLON_HM, POS_COLON_MS: need_sep = CHAR_COLON;
         default:                    need_sep = CHAR_NUL;
      endcase
   end

   // Pattern matching and digit gathering
   always_comb begin
      pos_in    = pos_ff;
      skip_in   = skip_ff;
      mis_in    = mis_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      if (cmd.take_char && !(skip_ff && is_blank)) begin
         skip_in = 1'b0;
         if (pos_ff < pat_len) begin
            pos_in = pos_ff + 5'd1;
            if (need_sep != CHAR_NUL) begin
               if (req_data.char_code != need_sep) mis_in = 1'b1;
            end else if (!is_digit) begin
               mis_in = 1'b1;
            end else if (pos_ff <= POS_YEAR_LAST) begin
               year_in = 14'(year_ff * 14'd10 + 14'(digit));
            end else if (pos_ff <= POS_MONTH_LAST) begin
               month_in = 7'(month_ff * 7'd10 + 7'(digit));
            end else if (pos_ff <= POS_DAY_LAST) begin
               day_in = 7'(day_ff * 7'd10 + 7'(digit));
            end else if (pos_ff <= POS_HOUR_LAST) begin
               hour_in = 7'(hour_ff * 7'd10 + 7'(digit));
            end else if (pos_ff <= POS_MINUTE_LAST) begin
               minute_in = 7'(minute_ff * 7'd10 + 7'(digit));
            end else begin
               second_in = 7'(second_ff * 7'd10 + 7'(digit));
            end
         end
      end
   end

   // Mode register and parser state; parser clears after each token
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= 1'b0;
      end else if (csr_valid) begin
         fmt_ff <= csr_data;
      end
      if (reset || cmd.capture) begin
         pos_ff    <= '0;
         skip_ff   <= 1'b1;
         mis_ff    <= 1'b0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         skip_ff   <= skip_in;
         mis_ff    <= mis_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
      end
   end

   // Token capture, including the last character
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         c_year_ff   <= year_in;
         c_month_ff  <= month_in;
         c_day_ff    <= day_in;
         c_hour_ff   <= hour_in;
         c_minute_ff <= minute_in;
         c_second_ff <= second_in;
         c_mode_ff   <= fmt_ff;
         c_err_ff    <= mis_in || (pos_in < pat_len);
      end
   end

   // Stage 1: January/February belong to the previous year
   always_comb begin
      if (c_month_ff <= 7'd2) begin
         s1_year_in = $signed({1'b0, c_year_ff}) - 15'sd1;
         s1_mi_in   = c_month_ff + 7'd9;
      end else begin
         s1_year_in = $signed({1'b0, c_year_ff});
         s1_mi_in   = c_month_ff - 7'd3;
      end
   end

   // Stage 2: era = floor(y/400) as (y>>4)/25; month term numerator
   assign era_prod  = 20'(s1_year_ff[13:4]) * 20'(RECIP_25);
   assign s2_era_in = s1_year_ff[14] ? -6'sd1 : $signed({1'b0, era_prod[19:15]});
   assign s2_t_in   = 15'(15'(s1_mi_ff) * 15'd153 + 15'd2);

   // Stage 3: year of era, day of year
   assign era_years = 16'(s2_era_ff) * 16'(ERA_YEARS);
   assign yoe_wide  = 16'(s1_year_ff) - era_years;
   assign s3_yoe_in = yoe_wide[8:0];
   assign doy_prod  = 28'(s2_t_ff) * 28'(RECIP_5);
   assign s3_doy_in = $signed({1'b0, doy_prod[27:16]}) + $signed({6'd0, c_day_ff}) - 13'sd1;

   // Stage 4: day of era, era offset, time of day
   assign cent_prod     = 14'(s3_yoe_ff) * 14'(RECIP_100);
   assign yoe_term      = 19'(19'(s3_yoe_ff) * 19'd365) + 19'(s3_yoe_ff[8:2])
                          - 19'(cent_prod[13:12]);
   assign s4_doe_in     = $signed(yoe_term) + 19'(s3_doy_ff);
   assign s4_eradays_in = 23'(s2_era_ff) * 23'(ERA_DAYS);
   assign s4_hms_in     = 19'(19'(c_hour_ff) * 19'd3600) + 19'(19'(c_minute_ff) * 19'd60)
                          + 19'(c_second_ff);

   // Stage 5: days since the epoch
   assign s5_days_in = s4_eradays_ff + 23'(s4_doe_ff) - 23'(EPOCH_SHIFT);

   // Stage 6: scale to seconds
   assign s6_prod_in = 40'(s5_days_ff) * 40'(DAY_SECONDS);

   always_ff @(posedge clock) begin
      s1_year_ff    <= s1_year_in;
      s1_mi_ff      <= s1_mi_in;
      s2_era_ff     <= s2_era_in;
      s2_t_ff       <= s2_t_in;
      s3_yoe_ff     <= s3_yoe_in;
      s3_doy_ff     <= s3_doy_in;
      s4_doe_ff     <= s4_doe_in;
      s4_eradays_ff <= s4_eradays_in;
      s4_hms_ff     <= s4_hms_in;
      s5_days_ff    <= s5_days_in;
      s6_prod_ff    <= s6_prod_in;
   end

   // Result select and output register
   always_comb begin
      if (c_err_ff) begin
         final_value = '0;
      end else if (c_mode_ff) begin
         final_value = s6_prod_ff[38:0] + $signed({20'd0, s4_hms_ff});
      end else begin
         final_value = 39'(s5_days_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.epoch_value  <= final_value;
         rsp_data_ff.format_error <= c_err_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ----- design/iso_date_time_to_epoch_parser_unit.sv -----
// ISO date/time to epoch parser, top level. Depends on isoep_pkg,
// isoep_ctrl, isoep_datapath and the assertion macro header.
//
// Usage: one ASCII character per transfer on req_ (valid/stall); the
// character flagged end_of_token closes the token. Leading blanks are
// skipped, then YYYY-MM-DD (csr_data = 0, days) or YYYY-MM-DD HH:MM:SS
// (csr_data = 1, seconds) is matched; trailing characters are ignored.
// One result per token on rsp_ (valid/stall): epoch_value, format_error.
// Throughput: one character per cycle within a token. The last character
// starts a fixed six-stage conversion sequence; req_stall stays high through
// it and the final step, so no character of the next token is taken meanwhile.
// rsp_valid rises when the final step loads the output register.
// A stalled result sits in the output register while the next token is
// taken; a further token end waits in the final step until it is taken.
// csr_ready is always high; write csr only while idle.
// Reset: synchronous, active high; clears the mode to date and the parser.
`include "iso_date_time_to_epoch_parser_unit_defines.svh"

module iso_date_time_to_epoch_parser_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  isoep_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output isoep_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data
);
   import isoep_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   isoep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   isoep_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // Input is held off once a token end is taken
   `ISOEP_ASSERT_NEXT(a_stall_after_token, cmd.capture, req_stall)
   // A new result only appears after a result load
   `ISOEP_ASSERT_IMPL(a_valid_from_load, $rose(rsp_valid), $past(cmd.load_out))
   // Error results carry a zero value
   `ISOEP_ASSERT_IMPL(a_error_zero, rsp_valid && rsp_data.format_error,
                      rsp_data.epoch_value == 39'sd0)

endmodule
